@@ hw/rtl/grid_bfs_shortest_path_unit_macros.svh @@
// Assertion macros shared by the grid search unit.
`ifndef GRID_BFS_SHORTEST_PATH_UNIT_MACROS_SVH
`define GRID_BFS_SHORTEST_PATH_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GBFS_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GBFS_CHECK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBFS_CHECK(lbl, clk, rst, prop, msg)
`define GBFS_CHECK_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hw/rtl/gbfs_pkg.sv @@
// Shared types and constants of the grid search unit.
package gbfs_pkg;
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;
   localparam int CFG_W = 7;
   localparam int LEN_W = 12;

   localparam logic [1:0] KIND_OPEN  = 2'd0;
   localparam logic [1:0] KIND_WALL  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;
   localparam logic [1:0] KIND_GOAL  = 2'd3;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic RES_VERDICT = 1'b0;
   localparam logic RES_MOVE    = 1'b1;

   localparam logic [2:0] ADDR_ROWS = 3'd0;
   localparam logic [2:0] ADDR_COLS = 3'd4;

   typedef struct packed {
      logic             result_kind;
      logic             found;
      logic [LEN_W-1:0] path_length;
      logic [1:0]       move;
      logic             move_valid;
      logic             last_move;
   } res_type;
endpackage

@@ hw/rtl/gbfs_div.sv @@
// Restoring divider that splits a cell index into row and column.
module gbfs_div #(
   parameter int NW = 12,
   parameter int DW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          busy,
   output logic [NW-1:0] quot,
   output logic [DW-1:0] rem
);
   localparam int CNW = $clog2(NW + 1);

   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic [NW-1:0]  q_ff, q_in;
   logic [DW:0]    r_ff, r_in;
   logic [DW:0]    sh;
   logic           ge;

   always_comb begin
      sh      = {r_ff[DW-1:0], q_ff[NW-1]};
      ge      = sh >= {1'b0, divisor};
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
         q_in    = dividend;
         r_in    = '0;
      end else if (busy_ff) begin
         r_in   = ge ? (sh - {1'b0, divisor}) : sh;
         q_in   = (q_ff << 1) | NW'(ge);
         cnt_in = cnt_ff + CNW'(1);
         if (cnt_ff == CNW'(NW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign busy = busy_ff;
   assign quot = q_ff;
   assign rem  = r_ff[DW-1:0];
endmodule

@@ hw/rtl/gbfs_core.sv @@
// Grid store, search queue, visit table, path store and the search sequencer.
`include "grid_bfs_shortest_path_unit_macros.svh"
module gbfs_core #(
   parameter int MAX_ROWS = gbfs_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = gbfs_pkg::DEF_MAX_COLS,
   parameter int RW = 7,
   parameter int CW = 7,
   parameter int TW = 13
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_op,
   input  logic [1:0]        req_kind,
   output logic              req_stall,
   input  logic [RW-1:0]     rows,
   input  logic [CW-1:0]     cols,
   input  logic [TW-1:0]     total,
   input  logic              res_take,
   output logic              res_valid,
   output gbfs_pkg::res_type res
);
   import gbfs_pkg::*;

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int IW = (CELLS > 1) ? $clog2(CELLS) : 1;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CLR  = 4'd1;
   localparam logic [3:0] S_DIV  = 4'd2;
   localparam logic [3:0] S_INIT = 4'd3;
   localparam logic [3:0] S_POP  = 4'd4;
   localparam logic [3:0] S_CUR  = 4'd5;
   localparam logic [3:0] S_CHK  = 4'd6;
   localparam logic [3:0] S_NBA  = 4'd7;
   localparam logic [3:0] S_NBB  = 4'd8;
   localparam logic [3:0] S_BTRD = 4'd9;
   localparam logic [3:0] S_BTWR = 4'd10;
   localparam logic [3:0] S_RDW  = 4'd11;
   localparam logic [3:0] S_EMIT = 4'd12;

   typedef struct packed {
      logic [IW-1:0] idx;
      logic [RW-1:0] row;
      logic [CW-1:0] col;
      logic [IW-1:0] len;
   } entry_type;

   // Storage.
   logic [1:0] cell_mem [CELLS];
   logic [2:0] node_mem [CELLS];
   entry_type  fifo_mem [CELLS];
   logic [1:0] path_mem [CELLS];

   logic [3:0]    state_ff, state_in;
   logic [TW-1:0] load_cnt_ff, load_cnt_in;
   logic [IW-1:0] start_ff, start_in;
   logic          seen_ff, seen_in;
   logic [IW-1:0] rp_ff, rp_in;
   logic [IW-1:0] moves_ff, moves_in;
   logic [TW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [RW-1:0] r_ff, r_in;
   logic [CW-1:0] c_ff, c_in;
   logic [IW-1:0] len_ff, len_in;
   logic [1:0]    dir_ff, dir_in;
   logic [IW-1:0] nb_ff, nb_in;
   logic [IW-1:0] p_ff, p_in;
   logic [IW-1:0] wpos_ff, wpos_in;
   res_type       res_ff, res_in;

   logic [1:0]    cell_rd_ff;
   logic [2:0]    node_rd_ff;
   entry_type     fifo_rd_ff;
   logic [1:0]    path_rd_ff;

   logic          cell_we, node_we, fifo_we, path_we;
   logic [IW-1:0] cell_waddr, node_waddr, path_waddr, cell_raddr, node_raddr;
   logic [IW-1:0] path_raddr;
   logic [1:0]    cell_wdata, path_wdata;
   logic [2:0]    node_wdata;
   entry_type     fifo_wdata;

   logic          div_start, div_busy;
   logic [IW-1:0] div_q;
   logic [CW-1:0] div_r;

   logic          accept, nb_ok, is_start, eff_seen;
   logic [TW-1:0] cnt_next;
   logic [IW-1:0] eff_start, colsw;
   logic [RW-1:0] nr;
   logic [CW-1:0] nc;
   logic [31:0]   len32;
   logic          pop_empty, miss_out;

   gbfs_div #(.NW(IW), .DW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (start_ff),
      .divisor  (cols),
      .busy     (div_busy),
      .quot     (div_q),
      .rem      (div_r)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign colsw     = IW'(cols);

   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      start_in    = start_ff;
      seen_in     = seen_ff;
      rp_in       = rp_ff;
      moves_in    = moves_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      clr_in      = clr_ff;
      cur_in      = cur_ff;
      r_in        = r_ff;
      c_in        = c_ff;
      len_in      = len_ff;
      dir_in      = dir_ff;
      nb_in       = nb_ff;
      p_in        = p_ff;
      wpos_in     = wpos_ff;
      res_in      = res_ff;
      cell_we     = 1'b0;
      cell_waddr  = load_cnt_ff[IW-1:0];
      cell_wdata  = req_kind;
      cell_raddr  = nb_ff;
      node_we     = 1'b0;
      node_waddr  = clr_ff;
      node_wdata  = 3'b000;
      node_raddr  = p_ff;
      fifo_we     = 1'b0;
      fifo_wdata  = '0;
      path_we     = 1'b0;
      path_waddr  = wpos_ff;
      path_wdata  = node_rd_ff[1:0];
      path_raddr  = rp_ff;
      div_start   = 1'b0;
      is_start    = 1'b0;
      eff_seen    = seen_ff;
      eff_start   = start_ff;
      cnt_next    = load_cnt_ff + TW'(1);
      nb_ok       = 1'b0;
      nr          = r_ff;
      nc          = c_ff;
      len32       = 32'(moves_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept && req_op == OP_LOAD) begin
               cell_we  = 1'b1;
               is_start = (req_kind == KIND_START) && !seen_ff;
               if (is_start) begin
                  eff_seen  = 1'b1;
                  eff_start = load_cnt_ff[IW-1:0];
               end
               seen_in     = eff_seen;
               start_in    = eff_start;
               load_cnt_in = cnt_next;
               if (cnt_next >= total) begin
                  load_cnt_in = '0;
                  seen_in     = 1'b0;
                  rp_in       = '0;
                  moves_in    = '0;
                  if (eff_seen && (TW'(eff_start) < total)) begin
                     clr_in   = '0;
                     state_in = S_CLR;
                  end else begin
                     res_in   = '{RES_VERDICT, 1'b0, '0, DIR_UP, 1'b0, 1'b0};
                     state_in = S_EMIT;
                  end
               end
            end else if (accept) begin
               res_in = '{RES_MOVE, 1'b0, '0, DIR_UP, 1'b0, 1'b0};
               if (rp_ff < moves_ff) begin
                  res_in.move_valid = 1'b1;
                  res_in.last_move  = (rp_ff + IW'(1)) == moves_ff;
                  rp_in             = rp_ff + IW'(1);
               end
               state_in = S_RDW;
            end
         end
         S_CLR: begin
            node_we = 1'b1;
            clr_in  = clr_ff + IW'(1);
            if (clr_ff == IW'(CELLS - 1)) begin
               // The queue starts empty, so the start entry lands in slot zero.
               head_in   = '0;
               tail_in   = '0;
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (!div_busy) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            node_we    = 1'b1;
            node_waddr = start_ff;
            node_wdata = 3'b100;
            fifo_we    = 1'b1;
            fifo_wdata = '{start_ff, RW'(div_q), div_r, '0};
            head_in    = '0;
            tail_in    = TW'(1);
            state_in   = S_POP;
         end
         S_POP: begin
            if (head_ff == tail_ff) begin
               moves_in = '0;
               res_in   = '{RES_VERDICT, 1'b0, '0, DIR_UP, 1'b0, 1'b0};
               state_in = S_EMIT;
            end else begin
               head_in  = head_ff + TW'(1);
               state_in = S_CUR;
            end
         end
         S_CUR: begin
            cur_in     = fifo_rd_ff.idx;
            r_in       = fifo_rd_ff.row;
            c_in       = fifo_rd_ff.col;
            len_in     = fifo_rd_ff.len;
            cell_raddr = fifo_rd_ff.idx;
            state_in   = S_CHK;
         end
         S_CHK: begin
            if (cell_rd_ff == KIND_GOAL) begin
               moves_in = len_ff;
               p_in     = cur_ff;
               wpos_in  = len_ff - IW'(1);
               len32    = 32'(len_ff);
               if (len_ff == '0) begin
                  res_in   = '{RES_VERDICT, 1'b1, '0, DIR_UP, 1'b0, 1'b0};
                  state_in = S_EMIT;
               end else begin
                  state_in = S_BTRD;
               end
            end else begin
               dir_in   = DIR_UP;
               state_in = S_NBA;
            end
         end
         S_NBA: begin
            case (dir_ff)
               DIR_UP: begin
                  nb_ok = (r_ff != '0);
                  nb_in = cur_ff - colsw;
               end
               DIR_DOWN: begin
                  nb_ok = ({1'b0, r_ff} + (RW + 1)'(1)) < {1'b0, rows};
                  nb_in = cur_ff + colsw;
               end
               DIR_LEFT: begin
                  nb_ok = (c_ff != '0);
                  nb_in = cur_ff - IW'(1);
               end
               default: begin
                  nb_ok = ({1'b0, c_ff} + (CW + 1)'(1)) < {1'b0, cols};
                  nb_in = cur_ff + IW'(1);
               end
            endcase
            cell_raddr = nb_in;
            node_raddr = nb_in;
            if (nb_ok) begin
               state_in = S_NBB;
            end else if (dir_ff == DIR_RIGHT) begin
               state_in = S_POP;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         S_NBB: begin
            case (dir_ff)
               DIR_UP:   nr = r_ff - RW'(1);
               DIR_DOWN: nr = r_ff + RW'(1);
               DIR_LEFT: nc = c_ff - CW'(1);
               default:  nc = c_ff + CW'(1);
            endcase
            if (cell_rd_ff != KIND_WALL && !node_rd_ff[2]) begin
               node_we    = 1'b1;
               node_waddr = nb_ff;
               node_wdata = {1'b1, dir_ff};
               fifo_we    = 1'b1;
               fifo_wdata = '{nb_ff, nr, nc, len_ff + IW'(1)};
               tail_in    = tail_ff + TW'(1);
            end
            if (dir_ff == DIR_RIGHT) begin
               state_in = S_POP;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = S_NBA;
            end
         end
         S_BTRD: begin
            state_in = S_BTWR;
         end
         S_BTWR: begin
            path_we = 1'b1;
            case (node_rd_ff[1:0])
               DIR_UP:   p_in = p_ff + colsw;
               DIR_DOWN: p_in = p_ff - colsw;
               DIR_LEFT: p_in = p_ff + IW'(1);
               default:  p_in = p_ff - IW'(1);
            endcase
            if (wpos_ff == '0) begin
               res_in = '{RES_VERDICT, 1'b1, len32[LEN_W-1:0], DIR_UP, 1'b0, 1'b0};
               state_in = S_EMIT;
            end else begin
               wpos_in  = wpos_ff - IW'(1);
               state_in = S_BTRD;
            end
         end
         S_RDW: begin
            if (res_ff.move_valid) begin
               res_in.move = path_rd_ff;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         load_cnt_ff <= '0;
         start_ff    <= '0;
         seen_ff     <= 1'b0;
         rp_ff       <= '0;
         moves_ff    <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         start_ff    <= start_in;
         seen_ff     <= seen_in;
         rp_ff       <= rp_in;
         moves_ff    <= moves_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
      end
      clr_ff  <= clr_in;
      cur_ff  <= cur_in;
      r_ff    <= r_in;
      c_ff    <= c_in;
      len_ff  <= len_in;
      dir_ff  <= dir_in;
      nb_ff   <= nb_in;
      p_ff    <= p_in;
      wpos_ff <= wpos_in;
      res_ff  <= res_in;
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      node_rd_ff <= node_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[tail_ff[IW-1:0]] <= fifo_wdata;
      end
      fifo_rd_ff <= fifo_mem[head_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (path_we) begin
         path_mem[path_waddr] <= path_wdata;
      end
      path_rd_ff <= path_mem[path_raddr];
   end

   assign res_valid = (state_ff == S_EMIT);
   assign res       = res_ff;

   assign pop_empty = (state_ff == S_POP) && (head_ff == tail_ff);
   assign miss_out  = res_valid && (res_ff.result_kind == RES_VERDICT) && !res_ff.found;

   `GBFS_CHECK(a_queue_order, clock, reset, head_ff <= tail_ff, "queue head passed tail")
   `GBFS_CHECK(a_empty_verdict, clock, reset, pop_empty |=> (res_valid && !res_ff.found), "empty hit")
   `GBFS_CHECK(a_miss_zero, clock, reset, miss_out |-> (res_ff.path_length == '0), "miss length")
   `GBFS_CHECK(a_read_ptr, clock, reset, rp_ff <= moves_ff, "read pointer beyond path")
endmodule

@@ hw/rtl/grid_bfs_shortest_path_unit.sv @@
// Top level of the grid breadth-first shortest path unit.
// The unit takes request items on the req_ channel: op 0 loads the next grid cell in
// row-major order, op 1 reads the next move of the last path found. Results leave on
// the rsp_ channel through one output register, so a waiting result never holds up
// the search logic beyond the single item that produced it.
// Grid size comes from two registers on the APB-style port (rows at byte 0, columns at
// byte 4); values are clamped to 1..MAX. Write them only while the unit is idle.
// A load that does not complete the grid gives no result, and the unit stays ready. The
// load that completes it starts a search when the grid has a start: a clearing pass over
// all MAX_ROWS*MAX_COLS visit entries at one per cycle, a divide of the start index, then
// per dequeued cell a dequeue, a cell read and a goal check, and per neighbor one bounds
// step plus a read-modify-write when it lies in the grid; a read and a write per path move
// then walk back from the goal.
// On small grids the clearing pass dominates the cost of each search.
// A read goes through the registered path memory read and the S_RDW state to its result.
// Reset clears all control state and the registers return to 64 by 64; grid and path
// memories are not cleared. While rsp_stall is high the result holds in the output
// register and the unit accepts no further item once a second result is ready.
module grid_bfs_shortest_path_unit #(
   parameter int MAX_ROWS = gbfs_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = gbfs_pkg::DEF_MAX_COLS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic [1:0]                     req_cell_kind,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_result_kind,
   output logic                           rsp_found,
   output logic [gbfs_pkg::LEN_W-1:0]     rsp_path_length,
   output logic [1:0]                     rsp_move,
   output logic                           rsp_move_valid,
   output logic                           rsp_last_move,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [2:0]                     paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import gbfs_pkg::*;

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int RW = $clog2(MAX_ROWS + 1);
   localparam int CW = $clog2(MAX_COLS + 1);
   localparam int TW = $clog2(CELLS + 1);

   logic [CFG_W-1:0] rows_cfg_ff, rows_cfg_in, cols_cfg_ff, cols_cfg_in;
   logic [RW-1:0]    rows_eff;
   logic [CW-1:0]    cols_eff;
   logic [TW-1:0]    total_eff;
   logic             csr_wr;

   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_ff, rsp_in;
   logic             res_valid, res_take;
   res_type          res;

   // Register writes and reads.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      rows_cfg_in = rows_cfg_ff;
      cols_cfg_in = cols_cfg_ff;
      if (csr_wr && paddr == ADDR_ROWS) begin
         rows_cfg_in = pwdata[CFG_W-1:0];
      end
      if (csr_wr && paddr == ADDR_COLS) begin
         cols_cfg_in = pwdata[CFG_W-1:0];
      end
      case (paddr)
         ADDR_ROWS: prdata = 32'(rows_cfg_ff);
         ADDR_COLS: prdata = 32'(cols_cfg_ff);
         default:   prdata = '0;
      endcase
   end

   // Clamp the sizes and form the cell count, so a new size holds from the next item on.
   always_comb begin
      if (rows_cfg_ff == '0) begin
         rows_eff = RW'(1);
      end else if (32'(rows_cfg_ff) > 32'(MAX_ROWS)) begin
         rows_eff = RW'(MAX_ROWS);
      end else begin
         rows_eff = RW'(rows_cfg_ff);
      end
      if (cols_cfg_ff == '0) begin
         cols_eff = CW'(1);
      end else if (32'(cols_cfg_ff) > 32'(MAX_COLS)) begin
         cols_eff = CW'(MAX_COLS);
      end else begin
         cols_eff = CW'(cols_cfg_ff);
      end
      total_eff = TW'(rows_eff) * TW'(cols_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= CFG_W'(64);
         cols_cfg_ff <= CFG_W'(64);
      end else begin
         rows_cfg_ff <= rows_cfg_in;
         cols_cfg_ff <= cols_cfg_in;
      end
   end

   gbfs_core #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .RW       (RW),
      .CW       (CW),
      .TW       (TW)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_kind  (req_cell_kind),
      .req_stall (req_stall),
      .rows      (rows_eff),
      .cols      (cols_eff),
      .total     (total_eff),
      .res_take  (res_take),
      .res_valid (res_valid),
      .res       (res)
   );

   // Output register: a result moves in when the slot is empty or being taken.
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_ff.result_kind;
   assign rsp_found       = rsp_ff.found;
   assign rsp_path_length = rsp_ff.path_length;
   assign rsp_move        = rsp_ff.move;
   assign rsp_move_valid  = rsp_ff.move_valid;
   assign rsp_last_move   = rsp_ff.last_move;
endmodule

@@ tb/sv/grid_bfs_shortest_path_unit_tb.sv @@
// Self-checking testbench for the grid breadth-first shortest path unit.
`timescale 1ns / 1ps
module grid_bfs_shortest_path_unit_tb;
   import gbfs_pkg::*;

   localparam int MAXR = DEF_MAX_ROWS;
   localparam int MAXC = DEF_MAX_COLS;
   localparam int NCELL = MAXR * MAXC;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic       op;
      logic [1:0] kind;
   } req_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = OP_LOAD;
   logic [1:0] req_cell_kind = KIND_OPEN;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_result_kind, rsp_found, rsp_move_valid, rsp_last_move;
   logic [LEN_W-1:0] rsp_path_length;
   logic [1:0] rsp_move;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   grid_bfs_shortest_path_unit i_dut (.*);

   always #4 clock = ~clock;

   // Predictor state: the unit's grid, search bookkeeping and stored path.
   logic [CFG_W-1:0] rows_reg = 7'd64, cols_reg = 7'd64;
   logic [1:0] grid_cells [NCELL];
   logic [1:0] entry_dir [NCELL];
   logic [1:0] path_moves [NCELL];
   bit seen_cell [NCELL];
   int bfs_queue [NCELL];
   int bfs_dist [NCELL];
   int cells_loaded = 0, start_cell = 0, move_ptr = 0, path_len = 0;
   bit have_start = 0;

   req_item_type pending_items[$];
   res_type expected_results[$];
   int errors = 0;
   int cycles = 0;
   bit hold_off = 0;
   bit hold_go = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int clamp_size(input logic [CFG_W-1:0] v, input int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Breadth-first search over the loaded grid; fills the path and returns found.
   function automatic bit search_path(input int nr, input int nc);
      int total, head, tail, cur, hops, r, c, nb, p;
      total = nr * nc;
      head = 0;
      tail = 0;
      foreach (seen_cell[i]) seen_cell[i] = 0;
      path_len = 0;
      move_ptr = 0;
      if (!have_start || start_cell >= total) return 0;
      seen_cell[start_cell] = 1;
      bfs_queue[0] = start_cell;
      bfs_dist[0] = 0;
      tail = 1;
      while (head < tail) begin
         cur = bfs_queue[head];
         hops = bfs_dist[head];
         r = cur / nc;
         c = cur % nc;
         head++;
         if (grid_cells[cur] == KIND_GOAL) begin
            // Walk back from the goal, filling moves from the end.
            p = cur;
            for (int k = 0; k < hops; k++) begin
               path_moves[hops-1-k] = entry_dir[p];
               case (entry_dir[p])
                  DIR_UP: p += nc;
                  DIR_DOWN: p -= nc;
                  DIR_LEFT: p += 1;
                  default: p -= 1;
               endcase
               if (p >= total || p < 0) break;
            end
            path_len = hops;
            return 1;
         end
         for (int d = 0; d < 4; d++) begin
            nb = -1;
            case (d)
               0: if (r > 0) nb = cur - nc;
               1: if (r + 1 < nr) nb = cur + nc;
               2: if (c > 0) nb = cur - 1;
               default: if (c + 1 < nc) nb = cur + 1;
            endcase
            if (nb < 0 || nb >= total) continue;
            if (grid_cells[nb] == KIND_WALL || seen_cell[nb]) continue;
            seen_cell[nb] = 1;
            entry_dir[nb] = d[1:0];
            bfs_queue[tail] = nb;
            bfs_dist[tail] = hops + 1;
            tail++;
         end
      end
      return 0;
   endfunction

   // Works out the result, if any, of one accepted item.
   function automatic void predict_result(input req_item_type it);
      res_type res;
      int nr, nc;
      res = '0;
      if (it.op == OP_LOAD) begin
         nr = clamp_size(rows_reg, MAXR);
         nc = clamp_size(cols_reg, MAXC);
         if (cells_loaded < NCELL) begin
            grid_cells[cells_loaded] = it.kind;
            if (it.kind == KIND_START && !have_start) begin
               have_start = 1;
               start_cell = cells_loaded;
            end
            cells_loaded++;
         end
         if (cells_loaded < nr * nc) return;
         res.result_kind = RES_VERDICT;
         res.found = search_path(nr, nc);
         res.path_length = path_len[LEN_W-1:0];
         cells_loaded = 0;
         have_start = 0;
      end else begin
         res.result_kind = RES_MOVE;
         if (move_ptr < path_len) begin
            res.move = path_moves[move_ptr];
            res.move_valid = 1'b1;
            res.last_move = (move_ptr + 1 == path_len);
            move_ptr++;
         end
      end
      expected_results.insert(expected_results.size(), res);
   endfunction

   // Acceptance seen at the rising edge, used by the sender at the next falling edge.
   bit accepted_q = 0;
   always @(posedge clock) begin
      accepted_q <= 0;
      if (!reset && req_valid && !req_stall) begin
         accepted_q <= 1;
         predict_result('{op: req_op, kind: req_cell_kind});
      end
   end

   // Sender: bursts of items separated by random gaps.
   int burst_left = 0, gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || accepted_q) begin
            if (gap_left > 0 || pending_items.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_op <= pending_items[0].op;
               req_cell_kind <= pending_items[0].kind;
               req_valid <= 1'b1;
               void'(pending_items.pop_front());
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
               end
            end
         end
      end
   end

   // Long receiver hold-off, counted here once it is asked for.
   int hold_left = 0;
   bit hold_done = 0;
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         if (hold_left == 1) hold_off <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_off <= 1'b1;
         hold_left = HOLD_CYCLES;
         hold_done = 1;
      end
   end

   // Receiver: its own stall pattern, plus the long hold-off.
   int stall_mode = 0;
   always @(negedge clock) begin
      if (cycles % 300 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= hold_off;
         1: rsp_stall <= hold_off || ($urandom_range(0, 3) == 0);
         default: rsp_stall <= hold_off || ($urandom_range(0, 1) == 0);
      endcase
   end

   // Monitor: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report("unexpected result_kind", 32'(rsp_result_kind), 32'd0);
         end else begin
            res_type want;
            want = expected_results.pop_front();
            if (rsp_result_kind !== want.result_kind)
               report("result_kind", 32'(rsp_result_kind), 32'(want.result_kind));
            if (rsp_found !== want.found)
               report("found", 32'(rsp_found), 32'(want.found));
            if (rsp_path_length !== want.path_length)
               report("path_length", 32'(rsp_path_length), 32'(want.path_length));
            if (rsp_move !== want.move)
               report("move", 32'(rsp_move), 32'(want.move));
            if (rsp_move_valid !== want.move_valid)
               report("move_valid", 32'(rsp_move_valid), 32'(want.move_valid));
            if (rsp_last_move !== want.last_move)
               report("last_move", 32'(rsp_last_move), 32'(want.last_move));
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_ROWS) rows_reg = value[CFG_W-1:0];
      else cols_reg = value[CFG_W-1:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Waits until the unit has answered everything and any trailing load has settled.
   task automatic drain();
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic queue_item(input logic op, input logic [1:0] kind);
      req_item_type it;
      it.op = op;
      it.kind = kind;
      pending_items.insert(pending_items.size(), it);
   endtask

   // One grid of the current size: mostly open cells and walls, a start, a goal and some random
   // kinds, then nr + nc + extra_reads items, mostly reads, that can go past the end of the path.
   task automatic queue_grid(input int nr, input int nc, input int extra_reads);
      int total, s, g;
      total = nr * nc;
      s = $urandom_range(0, total - 1);
      g = $urandom_range(0, total - 1);
      for (int i = 0; i < total; i++) begin
         if ($urandom_range(0, 19) == 0) queue_item(OP_LOAD, 2'($urandom_range(0, 3)));
         else if (i == s) queue_item(OP_LOAD, KIND_START);
         else if (i == g) queue_item(OP_LOAD, KIND_GOAL);
         else queue_item(OP_LOAD, ($urandom_range(0, 3) == 0) ? KIND_WALL : KIND_OPEN);
      end
      for (int i = 0; i < nr + nc + extra_reads; i++)
         queue_item(($urandom_range(0, 15) == 0) ? OP_LOAD : OP_READ,
                    2'($urandom_range(0, 3)));
   endtask

   initial begin
      int nr, nc, sent;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: one-cell grids without a start and with a lone start, then a 1x4 corridor.
      write_reg(ADDR_ROWS, 32'd1);
      write_reg(ADDR_COLS, 32'd1);
      queue_item(OP_LOAD, KIND_GOAL);     // missing start
      queue_item(OP_LOAD, KIND_START);    // start that is not a goal, nothing to reach
      queue_item(OP_READ, KIND_WALL);     // read of an empty path
      drain();
      write_reg(ADDR_COLS, 32'd4);
      queue_item(OP_LOAD, KIND_GOAL);
      queue_item(OP_LOAD, KIND_OPEN);
      queue_item(OP_LOAD, KIND_START);
      queue_item(OP_LOAD, KIND_START);    // a second start acts as open
      repeat (4) queue_item(OP_READ, KIND_GOAL);
      queue_item(OP_LOAD, KIND_START);    // walled off from the goal
      queue_item(OP_LOAD, KIND_WALL);
      queue_item(OP_LOAD, KIND_OPEN);
      queue_item(OP_LOAD, KIND_GOAL);
      queue_item(OP_READ, KIND_OPEN);
      drain();
      // The receiver holds off for a long stretch while reads keep being offered.
      hold_go = 1;
      repeat (12) queue_item(OP_READ, KIND_OPEN);
      drain();
      // Zero is used as one; values past the maximum are clamped.
      write_reg(ADDR_ROWS, 32'd0);
      write_reg(ADDR_COLS, 32'd127);
      queue_grid(1, MAXC, 4);
      drain();
      // Shrink mid-load: three cells loaded, then a 2x1 grid completes at once,
      // and the start beyond the new grid counts as missing.
      write_reg(ADDR_ROWS, 32'd2);
      write_reg(ADDR_COLS, 32'd2);
      queue_item(OP_LOAD, KIND_GOAL);
      queue_item(OP_LOAD, KIND_OPEN);
      queue_item(OP_LOAD, KIND_START);
      drain();
      write_reg(ADDR_COLS, 32'd1);
      queue_item(OP_LOAD, KIND_OPEN);
      drain();

      // Random part: mostly small grids of varied shape.
      sent = 0;
      while (sent < 750) begin
         nr = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 6);
         nc = $urandom_range(1, 8);
         write_reg(ADDR_ROWS, 32'(nr));
         write_reg(ADDR_COLS, 32'(nc));
         for (int g = 0; g < 3; g++) begin
            queue_grid(nr, nc, $urandom_range(0, 3));
            sent += nr * nc + nr + nc;
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
